// ===== design/tlv_ring_deframer_assert.svh =====
// assertion macros shared by the deframer modules
// no dependencies; taken in by `include in each asserting module
`ifndef TLV_RING_DEFRAMER_ASSERT_SVH
`define TLV_RING_DEFRAMER_ASSERT_SVH

// condition holds at every edge outside reset
`define TLVD_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TLVD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define TLVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tlvd_pkg.sv =====
// shared types and constants of the tlv ring deframer
// no dependencies
`timescale 1ns / 1ps

package tlvd_pkg;

   localparam int HEADER_BYTES = 13;
   localparam int LEN_OFFSET   = 9;
   localparam int FRAME_MAX    = 2048;
   localparam int CSR_W        = 12;
   localparam logic [CSR_W-1:0] MAX_FRAME_LEN_RESET = 12'd2048;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_OVERSIZE  = 2'd2,
      ST_NOT_READY = 2'd3
   } status_type;

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       frame_first;
      logic       frame_last;
      status_type status;
   } result_type;

endpackage

// ===== design/tlvd_if.sv =====
// request and response channel interfaces of the tlv ring deframer
// no dependencies
`timescale 1ns / 1ps

interface tlvd_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface tlvd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       frame_first;
   logic       frame_last;
   logic [1:0] status;

   modport source (output valid, output out_byte, output out_valid, output frame_first,
                   output frame_last, output status, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input frame_first,
                   input frame_last, input status, output ready);
endinterface

// ===== design/tlvd_front.sv =====
// front end: accepts requests, classifies them and holds them in a two-entry queue
// depends on tlvd_pkg and tlvd_req_if
`timescale 1ns / 1ps

module tlvd_front (
   input  logic              clock,
   input  logic              reset,
   tlvd_req_if.sink          req,
   output logic              q_valid,
   input  logic              q_ready,
   output tlvd_pkg::item_type q_item
);

   tlvd_pkg::item_type q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push_w;
   logic       pop_w;
   tlvd_pkg::item_type new_item;

   always_comb begin
      new_item.kind = req.req_type ? tlvd_pkg::KIND_POP : tlvd_pkg::KIND_PUSH;
      new_item.data = req.data_byte;
   end

   assign req.ready = (count_ff != 2'd2);
   assign push_w    = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop_w     = q_valid && q_ready;
   assign q_item    = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_w) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_w) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_w) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push_w, pop_w})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== design/tlvd_back.sv =====
// back end: ring memory, pointers, header length reader and response register
// depends on tlvd_pkg, tlvd_rsp_if and tlv_ring_deframer_assert.svh
`timescale 1ns / 1ps

`include "tlv_ring_deframer_assert.svh"

module tlvd_back #(
   parameter int RING_DEPTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  tlvd_pkg::item_type         q_item,
   input  logic                       csr_wr_en,
   input  logic [tlvd_pkg::CSR_W-1:0] csr_wr_data,
   tlvd_rsp_if.source                 rsp
);

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int LEN_W  = 13;

   typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RESUME, S_POPRD} state_type;

   state_type state_ff;
   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] rd_data_ff;
   logic [PTR_W-1:0] rp_ff, wp_ff, ld_addr_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [11:0] drain_rem_ff;
   logic draining_ff;
   logic hdr_ok_ff;
   logic [31:0] hdr_len_ff;
   logic [2:0] ld_cnt_ff;
   tlvd_pkg::kind_type kind_ff;
   logic pend_first_ff, pend_last_ff;
   logic [tlvd_pkg::CSR_W-1:0] max_frame_len_ff;
   logic rsp_valid_ff;
   tlvd_pkg::result_type res_ff;

   logic out_free;
   logic [tlvd_pkg::CSR_W-1:0] limit_w;
   logic [LEN_W-1:0] flen_w;
   logic over_w, short_w;
   logic [PTR_W:0] hdr_sum_w;
   logic [PTR_W-1:0] hdr_start_w;

   logic wr_en, take_w, load_w, flush_w, emit_w, rd_en;
   logic [PTR_W-1:0] rd_addr;
   tlvd_pkg::result_type emit_res;
   logic [11:0] drain_rem_in;
   logic draining_in, pend_first_in, pend_last_in;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic tlvd_pkg::result_type status_res(input tlvd_pkg::status_type s);
      tlvd_pkg::result_type r;
      r = '0;
      r.status = s;
      return r;
   endfunction

   // allowed frame length, capped at the build limit
   always_comb begin
      if (32'(max_frame_len_ff) > 32'(tlvd_pkg::FRAME_MAX)) begin
         limit_w = tlvd_pkg::CSR_W'(tlvd_pkg::FRAME_MAX);
      end else begin
         limit_w = max_frame_len_ff;
      end
   end

   assign flen_w  = {1'b0, hdr_len_ff[11:0]} + LEN_W'(tlvd_pkg::HEADER_BYTES);
   assign over_w  = (|hdr_len_ff[31:12]) || (flen_w > {1'b0, limit_w});
   assign short_w = 32'(fill_ff) < 32'(flen_w);

   always_comb begin
      hdr_sum_w = {1'b0, rp_ff} + (PTR_W+1)'(tlvd_pkg::LEN_OFFSET);
      if (hdr_sum_w >= (PTR_W+1)'(RING_DEPTH)) begin
         hdr_start_w = PTR_W'(hdr_sum_w - (PTR_W+1)'(RING_DEPTH));
      end else begin
         hdr_start_w = hdr_sum_w[PTR_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      wr_en         = 1'b0;
      take_w        = 1'b0;
      load_w        = 1'b0;
      flush_w       = 1'b0;
      emit_w        = 1'b0;
      q_ready       = 1'b0;
      emit_res      = status_res(tlvd_pkg::ST_OK);
      drain_rem_in  = drain_rem_ff;
      draining_in   = draining_ff;
      pend_first_in = 1'b0;
      pend_last_in  = 1'b0;
      rd_addr       = rp_ff;
      rd_en         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_ready = 1'b1;
               if (q_item.kind == tlvd_pkg::KIND_PUSH) begin
                  if (fill_ff == FILL_W'(RING_DEPTH)) begin
                     emit_w   = 1'b1;
                     emit_res = status_res(tlvd_pkg::ST_FULL);
                  end else begin
                     wr_en = 1'b1;
                     if (!draining_ff &&
                         fill_ff >= FILL_W'(tlvd_pkg::HEADER_BYTES - 1)) begin
                        if (!hdr_ok_ff) begin
                           load_w = 1'b1;
                        end else if (over_w) begin
                           flush_w  = 1'b1;
                           emit_w   = 1'b1;
                           emit_res = status_res(tlvd_pkg::ST_OVERSIZE);
                        end else begin
                           emit_w = 1'b1;
                        end
                     end else begin
                        emit_w = 1'b1;
                     end
                  end
               end else if (draining_ff) begin
                  take_w = 1'b1;
                  if (drain_rem_ff != 12'd0) begin
                     drain_rem_in = drain_rem_ff - 12'd1;
                  end
                  pend_last_in = (drain_rem_in == 12'd0);
                  draining_in  = !pend_last_in;
               end else if (fill_ff < FILL_W'(tlvd_pkg::HEADER_BYTES)) begin
                  emit_w   = 1'b1;
                  emit_res = status_res(tlvd_pkg::ST_NOT_READY);
               end else if (!hdr_ok_ff) begin
                  load_w = 1'b1;
               end else if (over_w) begin
                  flush_w  = 1'b1;
                  emit_w   = 1'b1;
                  emit_res = status_res(tlvd_pkg::ST_OVERSIZE);
               end else if (short_w) begin
                  emit_w   = 1'b1;
                  emit_res = status_res(tlvd_pkg::ST_NOT_READY);
               end else begin
                  take_w        = 1'b1;
                  pend_first_in = 1'b1;
                  drain_rem_in  = 12'(flen_w - LEN_W'(1));
                  pend_last_in  = (drain_rem_in == 12'd0);
                  draining_in   = !pend_last_in;
               end
            end
         end
         S_LOAD: begin
            rd_addr = ld_addr_ff;
            rd_en   = (ld_cnt_ff < 3'd4);
         end
         S_RESUME: begin
            if (over_w) begin
               flush_w  = 1'b1;
               emit_w   = 1'b1;
               emit_res = status_res(tlvd_pkg::ST_OVERSIZE);
            end else if (kind_ff == tlvd_pkg::KIND_PUSH) begin
               emit_w = 1'b1;
            end else if (short_w) begin
               emit_w   = 1'b1;
               emit_res = status_res(tlvd_pkg::ST_NOT_READY);
            end else begin
               take_w        = 1'b1;
               pend_first_in = 1'b1;
               drain_rem_in  = 12'(flen_w - LEN_W'(1));
               pend_last_in  = (drain_rem_in == 12'd0);
               draining_in   = !pend_last_in;
            end
         end
         S_POPRD: begin
            emit_w               = 1'b1;
            emit_res.out_byte    = rd_data_ff;
            emit_res.out_valid   = 1'b1;
            emit_res.frame_first = pend_first_ff;
            emit_res.frame_last  = pend_last_ff;
         end
         default: begin
            emit_w = 1'b0;
         end
      endcase
      if (take_w) begin
         rd_en = 1'b1;
      end
   end

   // ring memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wp_ff] <= q_item.data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rp_ff            <= '0;
         wp_ff            <= '0;
         fill_ff          <= '0;
         drain_rem_ff     <= '0;
         draining_ff      <= 1'b0;
         hdr_ok_ff        <= 1'b0;
         ld_cnt_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
         max_frame_len_ff <= tlvd_pkg::MAX_FRAME_LEN_RESET;
      end else begin
         if (csr_wr_en) begin
            max_frame_len_ff <= csr_wr_data;
         end
         if (emit_w) begin
            rsp_valid_ff <= 1'b1;
            res_ff       <= emit_res;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (flush_w) begin
            rp_ff        <= '0;
            wp_ff        <= '0;
            fill_ff      <= '0;
            drain_rem_ff <= '0;
            draining_ff  <= 1'b0;
            hdr_ok_ff    <= 1'b0;
         end else if (wr_en) begin
            wp_ff   <= wrap_inc(wp_ff);
            fill_ff <= fill_ff + 1'b1;
         end else if (take_w) begin
            rp_ff         <= wrap_inc(rp_ff);
            fill_ff       <= fill_ff - 1'b1;
            hdr_ok_ff     <= 1'b0;
            drain_rem_ff  <= drain_rem_in;
            draining_ff   <= draining_in;
            pend_first_ff <= pend_first_in;
            pend_last_ff  <= pend_last_in;
         end

         case (state_ff)
            S_IDLE: begin
               if (load_w) begin
                  state_ff   <= S_LOAD;
                  kind_ff    <= q_item.kind;
                  ld_addr_ff <= hdr_start_w;
                  ld_cnt_ff  <= '0;
               end else if (take_w) begin
                  state_ff <= S_POPRD;
               end
            end
            S_LOAD: begin
               if (rd_en) begin
                  ld_addr_ff <= wrap_inc(ld_addr_ff);
               end
               if (ld_cnt_ff != 3'd0) begin
                  hdr_len_ff <= {hdr_len_ff[23:0], rd_data_ff};
               end
               ld_cnt_ff <= ld_cnt_ff + 3'd1;
               if (ld_cnt_ff == 3'd4) begin
                  hdr_ok_ff <= 1'b1;
                  state_ff  <= S_RESUME;
               end
            end
            S_RESUME: begin
               state_ff <= take_w ? S_POPRD : S_IDLE;
            end
            S_POPRD: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = res_ff.out_byte;
   assign rsp.out_valid   = res_ff.out_valid;
   assign rsp.frame_first = res_ff.frame_first;
   assign rsp.frame_last  = res_ff.frame_last;
   assign rsp.status      = res_ff.status;

   `TLVD_ASSERT_HOLDS(a_fill_bound, clock, reset, fill_ff <= FILL_W'(RING_DEPTH), "fill over depth")
   `TLVD_ASSERT_IMPLIES(a_drain_has_data, clock, reset, draining_ff, fill_ff != '0, "drain with empty ring")
   `TLVD_ASSERT_IMPLIES(a_load_context, clock, reset, state_ff == S_LOAD, (!draining_ff) && (fill_ff >= FILL_W'(tlvd_pkg::HEADER_BYTES)), "header read out of context")
   `TLVD_ASSERT_NEXT(a_pop_emits, clock, reset, state_ff == S_POPRD, rsp_valid_ff && res_ff.out_valid, "frame byte not delivered")

endmodule

// ===== design/tlv_ring_deframer.sv =====
// tlv ring deframer top level: front request queue and back ring engine
// depends on tlvd_pkg, tlvd_if, tlvd_front and tlvd_back
`timescale 1ns / 1ps

// Reassembles length-prefixed frames (13-byte header, big-endian payload length at
// offset 9) from a byte stream held in a RING_DEPTH-byte ring. Each request pushes one
// byte or pops the next byte of a fully held frame, and gives exactly one response.
// Requests wait in a two-entry queue in front of the ring engine, so the request side
// keeps flowing while a response is stalled until that queue is full. A pop that hands
// out a byte goes on from the idle state through a read state, as the ring memory read
// is registered. The first request that needs the header of a new frame (a push
// completing it, or a pop at a frame boundary) waits while its four length bytes are
// read from the ring. The user must write max_frame_len through csr_wr_en/csr_wr_data
// only while the block is idle; the block does not enforce it.

module tlv_ring_deframer #(
   parameter int RING_DEPTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   tlvd_req_if.sink                   req_chan,
   tlvd_rsp_if.source                 rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [tlvd_pkg::CSR_W-1:0] csr_wr_data
);

   logic               q_valid;
   logic               q_ready;
   tlvd_pkg::item_type q_item;

   tlvd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item)
   );

   tlvd_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (rsp_chan)
   );

endmodule
